FILE: sv/dit_pkg.sv
// shared types and constants for the disjoint interval tracker
// no dependencies; imported by dit_map, dit_ctrl and disjoint_interval_tracker
package dit_pkg;

  // field widths
  localparam int VALUE_W     = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * VALUE_W;
  localparam int IN_PAD_W    = IN_TDATA_W - VALUE_W;

  // operation codes carried on in_tuser
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REPORT = 1'b1;

endpackage

FILE: sv/dit_map.sv
// presence map: one bit per value, single write port, single read port
// registered read data, valid in the cycle after the read; depends on dit_pkg
module dit_map
  import dit_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/dit_ctrl.sv
// sequencer: clearing pass, adds, report walk over the map and result register
// depends on dit_pkg; drives the ports of dit_map
module dit_ctrl
  import dit_pkg::*;
#(
  parameter int VALUE_COUNT = 128,
  parameter int AW          = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_op,
  input  logic [VALUE_W-1:0] in_value,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic               mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic               mem_rdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_start,
  output logic [VALUE_W-1:0] out_end,
  output logic               out_last,
  output logic               out_empty
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_EV, ST_FIN, ST_DONE
  } state_t;

  localparam logic [AW-1:0]    IDX_LAST = AW'(VALUE_COUNT - 1);
  localparam logic [VALUE_W:0] VAL_LIM  = (VALUE_W + 1)'(VALUE_COUNT);

  state_t             state_r, state_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic               in_run_r, in_run_nxt;
  logic [AW-1:0]      start_r, start_nxt;
  logic [AW-1:0]      end_r, end_nxt;
  logic               held_v_r, held_v_nxt;
  logic [AW-1:0]      hstart_r, hstart_nxt;
  logic [AW-1:0]      hend_r, hend_nxt;
  logic               out_v_r, out_v_nxt;
  logic [VALUE_W-1:0] ostart_r, ostart_nxt;
  logic [VALUE_W-1:0] oend_r, oend_nxt;
  logic               olast_r, olast_nxt;
  logic               oempty_r, oempty_nxt;

  logic out_free;
  logic bit_in;
  logic closing;
  logic need_push;
  logic in_range;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    in_run_nxt = in_run_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    held_v_nxt = held_v_r;
    hstart_nxt = hstart_r;
    hend_nxt   = hend_r;
    out_v_nxt  = out_v_r;
    ostart_nxt = ostart_r;
    oend_nxt   = oend_r;
    olast_nxt  = olast_r;
    oempty_nxt = oempty_r;

    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = idx_r;

    out_free  = !out_v_r || out_tready;
    // past the top of the map the walk sees an absent value
    bit_in    = (state_r == ST_EV) ? mem_rdata : 1'b0;
    closing   = in_run_r && !bit_in;
    need_push = closing && held_v_r;
    in_range  = {1'b0, in_value} < VAL_LIM;

    if (out_tready) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_op == OP_REPORT) begin
            idx_nxt    = '0;
            in_run_nxt = 1'b0;
            held_v_nxt = 1'b0;
            state_nxt  = ST_RD;
          end else if (in_range) begin
            mem_we    = 1'b1;
            mem_waddr = in_value[AW-1:0];
            mem_wdata = 1'b1;
          end
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_EV;
      end
      ST_EV, ST_FIN: begin
        // the run held back is not last once another run closes
        if (!(need_push && !out_free)) begin
          if (need_push) begin
            out_v_nxt  = 1'b1;
            ostart_nxt = VALUE_W'(hstart_r);
            oend_nxt   = VALUE_W'(hend_r);
            olast_nxt  = 1'b0;
            oempty_nxt = 1'b0;
          end
          if (closing) begin
            held_v_nxt = 1'b1;
            hstart_nxt = start_r;
            hend_nxt   = end_r;
            in_run_nxt = 1'b0;
          end
          if (bit_in) begin
            if (!in_run_r) begin
              start_nxt = idx_r;
            end
            end_nxt    = idx_r;
            in_run_nxt = 1'b1;
          end
          if (state_r == ST_FIN) begin
            state_nxt = ST_DONE;
          end else if (idx_r == IDX_LAST) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_v_nxt  = 1'b1;
          ostart_nxt = held_v_r ? VALUE_W'(hstart_r) : '0;
          oend_nxt   = held_v_r ? VALUE_W'(hend_r) : '0;
          olast_nxt  = 1'b1;
          oempty_nxt = !held_v_r;
          held_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      idx_r    <= '0;
      in_run_r <= 1'b0;
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      in_run_r <= in_run_nxt;
      held_v_r <= held_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    start_r  <= start_nxt;
    end_r    <= end_nxt;
    hstart_r <= hstart_nxt;
    hend_r   <= hend_nxt;
    ostart_r <= ostart_nxt;
    oend_r   <= oend_nxt;
    olast_r  <= olast_nxt;
    oempty_r <= oempty_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_start  = ostart_r;
  assign out_end    = oend_r;
  assign out_last   = olast_r;
  assign out_empty  = oempty_r;

endmodule

FILE: sv/disjoint_interval_tracker.sv
// top level of the disjoint interval tracker: stream ports, map and sequencer
// depends on dit_pkg, dit_map and dit_ctrl
//
// Keeps a one-bit presence map over the values 0 .. VALUE_COUNT-1 in a
// synchronous memory. An add transaction (in_tuser = 0) sets the bit of its
// value and gives no result; values at or above VALUE_COUNT are dropped. A
// report transaction (in_tuser = 1) walks the whole map, each entry taking
// a read state and then an evaluate state on the single read port, and
// sends each maximal run of present values as a start/end pair in
// ascending order, out_tlast marking the final run. An empty map gives
// one result with out_tuser (empty) set and zero start and end. The walk
// pauses while the result side stalls, and in_tready stays low until the
// report ends. After reset a clearing pass writes every entry to zero with
// in_tready low. One finished run is held back so that out_tlast can be
// set on it once the walk reaches the end of the map.
module disjoint_interval_tracker
  import dit_pkg::*;
#(
  parameter int VALUE_COUNT = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [6:0] value, [7] zero
  input  logic                   in_tuser,   // [0] op: 0 add, 1 report
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [6:0] run_start, [13:7] run_end, [15:14] zero
  output logic                   out_tlast,  // final result of a report
  output logic                   out_tuser   // [0] empty_res
);

  localparam int AW = $clog2(VALUE_COUNT);

  // map port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;

  logic [VALUE_W-1:0] run_start;
  logic [VALUE_W-1:0] run_end;

  dit_map #(
    .DEPTH (VALUE_COUNT),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dit_ctrl #(
    .VALUE_COUNT (VALUE_COUNT),
    .AW          (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_value   (in_tdata[VALUE_W-1:0]),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_start  (run_start),
    .out_end    (run_end),
    .out_last   (out_tlast),
    .out_empty  (out_tuser)
  );

  // pack the result transaction, start in the lowest bits
  assign out_tdata = {{OUT_PAD_W{1'b0}}, run_end, run_start};

`ifndef ASSERT_OFF
  // the map is never written and read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("map written and read in the same cycle");

  // no map read while new transactions are taken
  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mem_re)
    else $error("map read while accepting input");

  // an empty report is always a single, final result
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && run_start == '0 && run_end == '0))
    else $error("empty result not marked last or not zero");

  // a run never ends before it starts
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (run_start <= run_end))
    else $error("run end below run start");
`endif

endmodule
